// ===== rtl/core/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared widths, constants and payload types of the line resistance scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

   // field widths
   localparam int ADC_W  = 12;          // raw ADC code
   localparam int XP_W   = 24;          // code * reference millivolts
   localparam int MV_W   = 13;          // doubled millivolts, up to 6600
   localparam int NUM_W  = 24;          // 1925 * voltage difference
   localparam int OHM_W  = 23;          // corrected resistance
   localparam int LVL_W  = 10;          // scale level
   localparam int Y_W    = 32;          // rounded correction product
   localparam int MAPN_W = 21;          // interpolation numerator

   // conversion constants
   localparam int unsigned VREF_MV  = 3300;
   localparam int unsigned ADC_FULL = 4095;
   localparam int unsigned REF_OHM  = 1925;

   // supply factor: -346 + 673 * (10000 / 10) / 1000 with a fixed supply
   localparam int unsigned CORR_NUM   = 327;
   localparam int unsigned CORR_HALF  = 500;
   // floor(y / 1000) == (y * ceil(2^38 / 1000)) >> 38 for every y below 2^32
   localparam longint unsigned CORR_RECIP = 64'd274877907;
   localparam int CORR_SHIFT = 38;

   // threshold scale
   localparam int unsigned LO_OHM      = 248;
   localparam int unsigned HI_OHM      = 1800;
   localparam int unsigned LVL_NORMAL  = 1000;
   localparam int unsigned LVL_TRIGGER = 120;
   localparam int unsigned MAP_SPAN    = HI_OHM - LO_OHM;
   localparam int unsigned MAP_GAIN    = LVL_NORMAL - LVL_TRIGGER;
   localparam int unsigned MAP_HALF    = MAP_SPAN / 2;
   // span = 16 * 97: shift by four, then floor(v / 97) == (v * 86481) >> 23
   localparam int MAP_PRESHIFT = 4;
   localparam int MAPQ_W       = MAPN_W - MAP_PRESHIFT;
   localparam int unsigned MAP_RECIP = 86481;
   localparam int MAP_SHIFT = 23;
   localparam int MAPP_W    = 34;

   // divider layout
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = NUM_W / DIV_BITS;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_ENABLED = 1'b0,
      CSR_LEVEL_SWAP   = 1'b1
   } csr_index_type;

   // front end to divider
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [MV_W-1:0]  den;
      logic [ADC_W-1:0] high_raw;
   } div_req_type;

   // divider to back end
   typedef struct packed {
      logic [NUM_W-1:0] quo;
      logic [ADC_W-1:0] high_raw;
   } div_rsp_type;

   // result item
   typedef struct packed {
      logic [LVL_W-1:0] scaled_level;
      logic [OHM_W-1:0] corrected_ohm;
      logic [ADC_W-1:0] high_raw;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/lrs_if.sv =====
// ----------------------------------------------------------------------------
// lrs_req_if / lrs_rsp_if
// Valid/ready channels for ADC sample pairs and scaled results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrs_req_if;
   import lrs_pkg::*;
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_low;
   logic [ADC_W-1:0] adc_high;

   modport source (output valid, output adc_low, output adc_high, input ready);
   modport sink   (input valid, input adc_low, input adc_high, output ready);
endinterface

interface lrs_rsp_if;
   import lrs_pkg::*;
   logic             valid;
   logic             ready;
   logic [LVL_W-1:0] scaled_level;
   logic [OHM_W-1:0] corrected_ohm;
   logic [ADC_W-1:0] high_raw;

   modport source (output valid, output scaled_level, output corrected_ohm,
                   output high_raw, input ready);
   modport sink   (input valid, input scaled_level, input corrected_ohm,
                   input high_raw, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lrs_front.sv =====
// ----------------------------------------------------------------------------
// lrs_front
// Three stages: scale codes to millivolts, double and clamp, form the
// resistance numerator 1925 * (high - low) and the divisor low.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_front
   import lrs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [ADC_W-1:0] adc_low,
   input  wire logic [ADC_W-1:0] adc_high,
   output logic                  out_valid,
   output div_req_type           out_data
);

   // floor(x / 4095) for x = 4096a + b: a, plus one when a + b reaches 4095
   function automatic logic [MV_W-1:0] to_mv(input logic [XP_W-1:0] x);
      logic [ADC_W:0]   s;
      logic [ADC_W-1:0] q;
      s = {1'b0, x[XP_W-1:ADC_W]} + {1'b0, x[ADC_W-1:0]};
      q = x[XP_W-1:ADC_W] + ADC_W'(s >= (ADC_W+1)'(ADC_FULL));
      return {q, 1'b0};
   endfunction

   logic             v1_ff, v2_ff, v3_ff;
   logic [XP_W-1:0]  xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic [ADC_W-1:0] raw1_ff, raw2_ff, raw3_ff;
   logic [MV_W-1:0]  mlo_ff, mlo_in, mhi_ff, mhi_in;
   logic [MV_W-1:0]  diff;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [MV_W-1:0]  den_ff;

   assign xlo_in = XP_W'(adc_low) * XP_W'(VREF_MV);
   assign xhi_in = XP_W'(adc_high) * XP_W'(VREF_MV);

   always_comb begin
      mhi_in = to_mv(xhi_ff);
      mlo_in = to_mv(xlo_ff);
      if (mlo_in == '0) begin
         mlo_in = MV_W'(1);
      end
   end

   assign diff   = (mhi_ff > mlo_ff) ? (mhi_ff - mlo_ff) : '0;
   assign num_in = NUM_W'(diff) * NUM_W'(REF_OHM);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xlo_ff  <= xlo_in;
         xhi_ff  <= xhi_in;
         raw1_ff <= adc_high;
         mlo_ff  <= mlo_in;
         mhi_ff  <= mhi_in;
         raw2_ff <= raw1_ff;
         num_ff  <= num_in;
         den_ff  <= mlo_ff;
         raw3_ff <= raw2_ff;
      end
   end

   assign out_valid         = v3_ff;
   assign out_data.num      = num_ff;
   assign out_data.den      = den_ff;
   assign out_data.high_raw = raw3_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lrs_div.sv =====
// ----------------------------------------------------------------------------
// lrs_div
// Pipelined restoring divider: two quotient bits per stage, one stage per
// register, the numerator shifting out as the quotient shifts in.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_div
   import lrs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire div_req_type in_data,
   output logic             out_valid,
   output div_rsp_type      out_data
);

   typedef struct packed {
      logic [MV_W-1:0]  rem;
      logic [NUM_W-1:0] num;
   } div_acc_type;

   function automatic div_acc_type div_step(input div_acc_type acc_in,
                                            input logic [MV_W-1:0] den);
      div_acc_type   acc;
      logic [MV_W:0] trial;
      acc = acc_in;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {acc.rem, acc.num[NUM_W-1]};
         if (trial >= {1'b0, den}) begin
            acc.rem = MV_W'(trial - {1'b0, den});
            acc.num = {acc.num[NUM_W-2:0], 1'b1};
         end else begin
            acc.rem = trial[MV_W-1:0];
            acc.num = {acc.num[NUM_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

   div_acc_type      acc_ff [DIV_STAGES];
   logic [MV_W-1:0]  den_ff [DIV_STAGES];
   logic [ADC_W-1:0] raw_ff [DIV_STAGES];
   logic             v_ff   [DIV_STAGES];
   div_acc_type      acc0;

   assign acc0.rem = '0;
   assign acc0.num = in_data.num;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      div_acc_type      acc_in;
      logic [MV_W-1:0]  den_in;
      logic [ADC_W-1:0] raw_in;
      logic             v_in;

      if (s == 0) begin : g_first
         assign acc_in = div_step(acc0, in_data.den);
         assign den_in = in_data.den;
         assign raw_in = in_data.high_raw;
         assign v_in   = in_valid;
      end else begin : g_next
         assign acc_in = div_step(acc_ff[s-1], den_ff[s-1]);
         assign den_in = den_ff[s-1];
         assign raw_in = raw_ff[s-1];
         assign v_in   = v_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[s] <= acc_in;
            den_ff[s] <= den_in;
            raw_ff[s] <= raw_in;
         end
      end
   end

   assign out_valid         = v_ff[DIV_STAGES-1];
   assign out_data.quo      = acc_ff[DIV_STAGES-1].num;
   assign out_data.high_raw = raw_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/lrs_back.sv =====
// ----------------------------------------------------------------------------
// lrs_back
// Four stages: apply the 327/1000 supply factor with rounding, then map the
// corrected resistance onto the threshold scale by rounded interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_back
   import lrs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        level_swap,
   input  wire logic        in_valid,
   input  wire div_rsp_type in_data,
   output logic             out_valid,
   output rsp_type          out_data
);

   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic [ADC_W-1:0]  raw1_ff, raw2_ff, raw3_ff, raw4_ff;
   logic [Y_W-1:0]    y_ff, y_in;
   logic [63:0]       corr_prod;
   logic [OHM_W-1:0]  corr2_ff, corr_in, corr3_ff, corr4_ff;
   logic              le3_ff, ge3_ff, le4_ff, ge4_ff;
   logic [10:0]       off;
   logic [MAPN_W-1:0] n_ff, n_in;
   logic [MAPP_W-1:0] map_prod;
   logic [LVL_W-1:0]  q_ff, q_in;
   logic [LVL_W-1:0]  at_normal, at_trigger;

   // y = r * 327 + 500, then corrected = floor(y / 1000) by reciprocal
   assign y_in      = Y_W'(in_data.quo) * Y_W'(CORR_NUM) + Y_W'(CORR_HALF);
   assign corr_prod = 64'(y_ff) * CORR_RECIP;
   assign corr_in   = corr_prod[CORR_SHIFT +: OHM_W];

   // only meaningful strictly between the two thresholds, where corr fits 11 bits
   assign off  = 11'(corr2_ff) - 11'(LO_OHM);
   assign n_in = MAPN_W'(off) * MAPN_W'(MAP_GAIN) + MAPN_W'(MAP_HALF);

   assign map_prod = MAPP_W'(n_ff[MAPN_W-1:MAP_PRESHIFT]) * MAPP_W'(MAP_RECIP);
   assign q_in     = map_prod[MAP_SHIFT +: LVL_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff     <= y_in;
         raw1_ff  <= in_data.high_raw;
         corr2_ff <= corr_in;
         raw2_ff  <= raw1_ff;
         n_ff     <= n_in;
         le3_ff   <= (corr2_ff <= OHM_W'(LO_OHM));
         ge3_ff   <= (corr2_ff >= OHM_W'(HI_OHM));
         corr3_ff <= corr2_ff;
         raw3_ff  <= raw2_ff;
         q_ff     <= q_in;
         le4_ff   <= le3_ff;
         ge4_ff   <= ge3_ff;
         corr4_ff <= corr3_ff;
         raw4_ff  <= raw3_ff;
      end
   end

   assign at_normal  = level_swap ? LVL_W'(LVL_TRIGGER) : LVL_W'(LVL_NORMAL);
   assign at_trigger = level_swap ? LVL_W'(LVL_NORMAL) : LVL_W'(LVL_TRIGGER);

   always_comb begin
      if (le4_ff) begin
         out_data.scaled_level = at_normal;
      end else if (ge4_ff) begin
         out_data.scaled_level = at_trigger;
      end else if (level_swap) begin
         out_data.scaled_level = at_normal + q_ff;
      end else begin
         out_data.scaled_level = at_normal - q_ff;
      end
   end

   assign out_data.corrected_ohm = corr4_ff;
   assign out_data.high_raw      = raw4_ff;
   assign out_valid              = v4_ff;

endmodule

`default_nettype wire

// ===== rtl/core/line_resistance_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// line_resistance_scaler_unit
// Converts ADC sample pairs of a detector loop into a corrected loop
// resistance and a level on the threshold scale.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries adc_low / adc_high; an item is taken when valid and ready
//   are both high. rsp_ch returns scaled_level, corrected_ohm and high_raw.
//   csr_wr_en writes csr_wdata bit 0 into the register chosen by csr_index
//   (line_enabled, level_swap); write only while no item is in flight.
//   With line_enabled low, items are taken and dropped without a result.
// Timing:
//   One item per cycle while the skid register is empty. A result passes
//   three front stages, twelve divider stages at two quotient bits each,
//   four correction and mapping stages, and the output register.
// Reset:
//   Synchronous, active high. Empties the pipeline, sets line_enabled to 1
//   and level_swap to 0.
// Backpressure:
//   The whole pipeline freezes while the skid register holds an item; the
//   skid fills only when rsp_ch stalls as a result arrives, so req_ch.ready
//   drops in the cycle after that and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module line_resistance_scaler_unit
   import lrs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   lrs_req_if.sink                   req_ch,
   lrs_rsp_if.source                 rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   logic        line_enabled_ff, level_swap_ff;
   logic        en;
   logic        front_valid, div_valid, back_valid;
   div_req_type front_data;
   div_rsp_type div_data;
   rsp_type     back_data;
   logic        out_v_ff, skid_v_ff;
   rsp_type     out_ff, skid_ff;

   // advance everything unless the skid holds an item
   assign en           = ~skid_v_ff;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_enabled_ff <= 1'b1;
         level_swap_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LINE_ENABLED: line_enabled_ff <= csr_wdata[0];
            CSR_LEVEL_SWAP:   level_swap_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   lrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid & line_enabled_ff),
      .adc_low   (req_ch.adc_low),
      .adc_high  (req_ch.adc_high),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   lrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   lrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .level_swap (level_swap_ff),
      .in_valid   (div_valid),
      .in_data    (div_data),
      .out_valid  (back_valid),
      .out_data   (back_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_v_ff && !rsp_ch.ready) begin
         // hold the output; park an arriving item in the skid
         if (en && back_valid) begin
            skid_v_ff <= 1'b1;
         end
      end else if (skid_v_ff) begin
         out_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff <= back_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_v_ff && !rsp_ch.ready) begin
         if (en) begin
            skid_ff <= back_data;
         end
      end else if (skid_v_ff) begin
         out_ff <= skid_ff;
      end else begin
         out_ff <= back_data;
      end
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.scaled_level  = out_ff.scaled_level;
   assign rsp_ch.corrected_ohm = out_ff.corrected_ohm;
   assign rsp_ch.high_raw      = out_ff.high_raw;

   a_skid_has_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ch.ready))
      else $error("skid filled without a stalled output");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.scaled_level >= LVL_W'(LVL_TRIGGER)) &&
                       (rsp_ch.scaled_level <= LVL_W'(LVL_NORMAL)))
      else $error("scaled level outside the threshold scale");

   a_zero_ohm_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.corrected_ohm == '0) |->
         (rsp_ch.scaled_level == LVL_W'(LVL_NORMAL) ||
          rsp_ch.scaled_level == LVL_W'(LVL_TRIGGER)))
      else $error("zero resistance mapped between the scale ends");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_resistance_scaler_unit. A short table of
// directed sample pairs runs first, then randomized phases under random
// register settings. Each result is compared field by field against the
// table's expected values or an in-bench loop resistance predictor, with
// bursty inputs and a receiver that stalls on patterns of its own.
// ----------------------------------------------------------------------------
module testbench
   import lrs_pkg::*;
;

   localparam int unsigned REF_MILLIVOLTS = 3300;
   localparam int unsigned CODE_SPAN      = 4095;
   localparam int unsigned LOOP_OHM       = 1925;
   localparam int unsigned SUPPLY_GAIN    = 327;
   localparam int unsigned FLOOR_OHM      = 248;
   localparam int unsigned CEIL_OHM       = 1800;
   localparam int unsigned LEVEL_OPEN     = 1000;
   localparam int unsigned LEVEL_TRIP     = 120;

   localparam int RANDOM_ITEMS  = 1750;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_LIMIT    = 2000;
   localparam int MAX_REPORTS   = 10;
   localparam int NUM_ROWS      = 23;

   typedef struct packed {
      logic        en;
      logic        nc;
      logic [11:0] lo;
      logic [11:0] hi;
      logic        known;
      logic [9:0]  lvl;
      logic [22:0] ohm;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   lrs_req_if req_ch ();
   lrs_rsp_if rsp_ch ();

   line_resistance_scaler_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bench copy of the registers
   logic line_on;
   logic swap_on;

   rsp_type expected_readings [$];
   stim_row_type rows [0:NUM_ROWS-1];

   int items_taken;
   int items_dropped;
   int readings_checked;
   int setting_changes;
   int fail_count;
   int idle_cycles;
   int burst_left;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type predict_reading(logic [11:0] lo_code, logic [11:0] hi_code,
                                                logic swapped);
      int unsigned     lo_mv;
      int unsigned     hi_mv;
      int unsigned     at_open;
      longint unsigned ohm;
      longint unsigned corr;
      longint unsigned level;
      longint unsigned q;
      rsp_type         r;
      lo_mv = (int'(lo_code) * REF_MILLIVOLTS / CODE_SPAN) * 2;
      hi_mv = (int'(hi_code) * REF_MILLIVOLTS / CODE_SPAN) * 2;
      if (lo_mv == 0) lo_mv = 1;
      ohm = 0;
      if (hi_mv > lo_mv) begin
         ohm = LOOP_OHM;
         ohm = ohm * (hi_mv - lo_mv) / lo_mv;
      end
      corr = (ohm * SUPPLY_GAIN + 500) / 1000;
      at_open = swapped ? LEVEL_TRIP : LEVEL_OPEN;
      if (corr <= FLOOR_OHM) begin
         level = at_open;
      end else if (corr >= CEIL_OHM) begin
         level = swapped ? LEVEL_OPEN : LEVEL_TRIP;
      end else begin
         // round half up on the magnitude of the step
         q = ((corr - FLOOR_OHM) * (LEVEL_OPEN - LEVEL_TRIP) + (CEIL_OHM - FLOOR_OHM) / 2)
             / (CEIL_OHM - FLOOR_OHM);
         level = swapped ? at_open + q : at_open - q;
      end
      r.scaled_level  = level[LVL_W-1:0];
      r.corrected_ohm = corr[OHM_W-1:0];
      r.high_raw      = hi_code;
      return r;
   endfunction

   function automatic void pick_pair(output logic [11:0] lo, output logic [11:0] hi);
      int unsigned mode;
      int unsigned lo_i;
      int unsigned hi_i;
      int unsigned target;
      int unsigned ends [4];
      rsp_type     probe;
      ends = '{0, 1, 4094, 4095};
      mode = $urandom_range(0, 99);
      if (mode < 20) begin
         lo_i = $urandom_range(0, 4095);
         hi_i = $urandom_range(0, 4095);
      end else if (mode < 55) begin
         // ratio that lands mostly inside the interpolation window
         lo_i = $urandom_range(150, 1800);
         hi_i = lo_i + lo_i * $urandom_range(300, 3200) / 1000;
      end else if (mode < 70) begin
         // hunt for the code closest to a scale threshold
         lo_i = $urandom_range(100, 2000);
         case ($urandom_range(0, 3))
            0: target = FLOOR_OHM;
            1: target = FLOOR_OHM + 1;
            2: target = CEIL_OHM - 1;
            default: target = CEIL_OHM;
         endcase
         hi_i = lo_i;
         probe = predict_reading(lo_i[11:0], hi_i[11:0], 1'b0);
         while (hi_i < 4095 && probe.corrected_ohm < target) begin
            hi_i++;
            probe = predict_reading(lo_i[11:0], hi_i[11:0], 1'b0);
         end
         hi_i = hi_i + $urandom_range(0, 2);
         if (hi_i > 0) hi_i = hi_i - 1;
      end else if (mode < 82) begin
         hi_i = $urandom_range(0, 4095);
         lo_i = $urandom_range(hi_i, 4095);
      end else if (mode < 92) begin
         lo_i = $urandom_range(0, 6);
         hi_i = $urandom_range(0, 4095);
      end else begin
         lo_i = ends[$urandom_range(0, 3)];
         hi_i = ends[$urandom_range(0, 3)];
      end
      if (hi_i > 4095) hi_i = 4095;
      lo = lo_i[11:0];
      hi = hi_i[11:0];
   endfunction

   // present one item, hold it until taken, record what it should produce
   task automatic push_item(logic [11:0] lo, logic [11:0] hi, logic use_typed,
                            rsp_type typed);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 10);
         end
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.adc_low  <= lo;
      req_ch.adc_high <= hi;
      do @(posedge clock); while (!req_ch.ready);
      items_taken++;
      if (use_typed)
         expected_readings.push_back(typed);
      else if (line_on)
         expected_readings.push_back(predict_reading(lo, hi, swap_on));
      else
         items_dropped++;
      @(negedge clock);
   endtask

   // drain results, then let dropped items clear the pipeline
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(logic en, logic nc);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LINE_ENABLED;
      csr_wdata <= en;
      @(negedge clock);
      csr_index <= CSR_LEVEL_SWAP;
      csr_wdata <= nc;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      line_on = en;
      swap_on = nc;
      setting_changes++;
   endtask

   // receiver: segments of always-ready, coin flips, rotating masks, heavy stall
   int          rx_left = 0;
   int          rx_mode = 0;
   logic [7:0]  rx_mask = 8'hFF;
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_left = $urandom_range(20, 200);
         rx_mode = $urandom_range(0, 3);
         rx_mask = 8'($urandom_range(1, 255));
      end
      rx_left--;
      case (rx_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2: begin
            rsp_ch.ready <= rx_mask[0];
            rx_mask = {rx_mask[0], rx_mask[7:1]};
         end
         default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.scaled_level  = rsp_ch.scaled_level;
            got.corrected_ohm = rsp_ch.corrected_ohm;
            got.high_raw      = rsp_ch.high_raw;
            if (expected_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected result: level %0d ohm %0d high %0d",
                           got.scaled_level, got.corrected_ohm, got.high_raw);
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (got.scaled_level !== want.scaled_level ||
                   got.corrected_ohm !== want.corrected_ohm ||
                   got.high_raw !== want.high_raw) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("mismatch #%0d: level %0d/%0d ohm %0d/%0d high %0d/%0d %s",
                              readings_checked, want.scaled_level, got.scaled_level,
                              want.corrected_ohm, got.corrected_ohm, want.high_raw,
                              got.high_raw, "(expected/actual)");
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_readings.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      rsp_type     typed;
      logic [11:0] lo;
      logic [11:0] hi;
      logic        en;
      logic        nc;
      int          random_items;
      int          phase_len;

      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_LINE_ENABLED;
      csr_wdata       = 1'b0;
      req_ch.valid    = 1'b0;
      req_ch.adc_low  = '0;
      req_ch.adc_high = '0;
      line_on         = 1'b1;
      swap_on         = 1'b0;
      items_taken     = 0;
      items_dropped   = 0;
      readings_checked = 0;
      setting_changes = 0;
      fail_count      = 0;
      idle_cycles     = 0;
      burst_left      = 0;
      random_items    = 0;

      //        en    nc    lo        hi        known lvl     ohm
      rows = '{
         '{1'b1, 1'b0, 12'd0,    12'd0,    1'b1, 10'd1000, 23'd0},
         '{1'b1, 1'b0, 12'd4095, 12'd4095, 1'b1, 10'd1000, 23'd0},
         '{1'b1, 1'b0, 12'd0,    12'd4095, 1'b1, 10'd120,  23'd4153906},
         '{1'b1, 1'b0, 12'd4095, 12'd0,    1'b1, 10'd1000, 23'd0},
         '{1'b1, 1'b0, 12'd1,    12'd4095, 1'b1, 10'd120,  23'd4153906},
         '{1'b1, 1'b0, 12'd2,    12'd4095, 1'b0, 10'd0,    23'd0},
         '{1'b1, 1'b0, 12'd2048, 12'd2047, 1'b1, 10'd1000, 23'd0},
         '{1'b1, 1'b0, 12'd1000, 12'd1500, 1'b0, 10'd0,    23'd0},
         '{1'b1, 1'b0, 12'd1000, 12'd2000, 1'b0, 10'd0,    23'd0},
         '{1'b1, 1'b0, 12'd1000, 12'd3000, 1'b0, 10'd0,    23'd0},
         '{1'b1, 1'b0, 12'd2000, 12'd2500, 1'b0, 10'd0,    23'd0},
         '{1'b1, 1'b0, 12'hAAA,  12'h555,  1'b1, 10'd1000, 23'd0},
         '{1'b1, 1'b0, 12'h555,  12'hAAA,  1'b0, 10'd0,    23'd0},
         '{1'b1, 1'b1, 12'd0,    12'd0,    1'b1, 10'd120,  23'd0},
         '{1'b1, 1'b1, 12'd0,    12'd4095, 1'b1, 10'd1000, 23'd4153906},
         '{1'b1, 1'b1, 12'd1000, 12'd1500, 1'b0, 10'd0,    23'd0},
         '{1'b1, 1'b1, 12'd4095, 12'd4095, 1'b1, 10'd120,  23'd0},
         '{1'b1, 1'b1, 12'd600,  12'd1800, 1'b0, 10'd0,    23'd0},
         '{1'b0, 1'b1, 12'd0,    12'd4095, 1'b0, 10'd0,    23'd0},
         '{1'b0, 1'b1, 12'd1234, 12'd2345, 1'b0, 10'd0,    23'd0},
         '{1'b0, 1'b0, 12'd4095, 12'd0,    1'b0, 10'd0,    23'd0},
         '{1'b1, 1'b0, 12'd0,    12'd4095, 1'b1, 10'd120,  23'd4153906},
         '{1'b1, 1'b0, 12'd3000, 12'd3200, 1'b0, 10'd0,    23'd0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table; the first rows run on the reset settings
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (rows[i].en != line_on || rows[i].nc != swap_on) begin
            settle();
            apply_settings(rows[i].en, rows[i].nc);
         end
         typed.scaled_level  = rows[i].lvl;
         typed.corrected_ohm = rows[i].ohm;
         typed.high_raw      = rows[i].hi;
         push_item(rows[i].lo, rows[i].hi, rows[i].known, typed);
      end

      // random phases, mostly enabled, with short disabled stretches
      while (random_items < RANDOM_ITEMS) begin
         en = ($urandom_range(0, 9) != 0);
         nc = 1'($urandom_range(0, 1));
         if (en != line_on || nc != swap_on) begin
            settle();
            apply_settings(en, nc);
         end
         phase_len = en ? $urandom_range(40, 250) : $urandom_range(10, 40);
         repeat (phase_len) begin
            pick_pair(lo, hi);
            push_item(lo, hi, 1'b0, typed);
            if (en) random_items++;
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d sample pairs (%0d dropped on a disabled line)",
               items_taken, items_dropped);
      $display("%0d results checked across %0d register updates and all four settings",
               readings_checked, setting_changes);
      if (fail_count == 0 && expected_readings.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/lrs_pkg.sv
rtl/core/lrs_if.sv
rtl/core/lrs_front.sv
rtl/core/lrs_div.sv
rtl/core/lrs_back.sv
rtl/core/line_resistance_scaler_unit.sv
sim/testbench.sv
